[rtl/sti_pkg.sv]
// Shared request and result types for the segment/triangle intersection core.
package sti_pkg;

  localparam int unsigned FieldW = 48;
  localparam int unsigned IdW    = 16;
  localparam int unsigned TolW   = 16;

  typedef struct packed {
    logic [IdW-1:0]    seg_id;
    logic [IdW-1:0]    tri_id;
    logic [FieldW-1:0] seg_end;
    logic [FieldW-1:0] seg_start;
    logic [FieldW-1:0] vertex_c;
    logic [FieldW-1:0] vertex_b;
    logic [FieldW-1:0] vertex_a;
  } sti_req_t;

  typedef struct packed {
    logic              hit;
    logic [FieldW-1:0] contact_point;
    logic [IdW-1:0]    tri_id_out;
    logic [IdW-1:0]    seg_id_out;
  } sti_res_t;

endpackage

[rtl/sti_geom.sv]
// Four-stage pipeline that forms the Cramer determinants of the intersection system.
module sti_geom #(
  parameter int unsigned CB = 16,
  localparam int unsigned W = 3 * CB + 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  sti_pkg::sti_req_t       req_i,
  output logic                    valid_o,
  output logic signed [W-1:0]     det_o,
  output logic signed [W-1:0]     nu_o,
  output logic signed [W-1:0]     nv_o,
  output logic signed [W-1:0]     nt_o,
  output logic signed [CB-1:0]    p_o [3],
  output logic signed [CB:0]      pq_o [3],
  output logic [sti_pkg::IdW-1:0] tri_id_o,
  output logic [sti_pkg::IdW-1:0] seg_id_o
);
  import sti_pkg::*;

  localparam int unsigned XW = (3 * CB > FieldW) ? 3 * CB : FieldW;
  localparam int unsigned PW = 2 * CB + 2;
  localparam int unsigned KW = 2 * CB + 3;
  localparam int unsigned DW = 3 * CB + 4;
  localparam int unsigned NXT [3] = '{1, 2, 0};
  localparam int unsigned PRV [3] = '{2, 0, 1};

  logic [XW-1:0] wa, wb, wc, wp, wq;
  logic signed [CB-1:0] a [3], b [3], c [3], p [3], q [3];

  assign wa = XW'(req_i.vertex_a);
  assign wb = XW'(req_i.vertex_b);
  assign wc = XW'(req_i.vertex_c);
  assign wp = XW'(req_i.seg_start);
  assign wq = XW'(req_i.seg_end);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i] = wa[i*CB +: CB];
      b[i] = wb[i*CB +: CB];
      c[i] = wc[i*CB +: CB];
      p[i] = wp[i*CB +: CB];
      q[i] = wq[i*CB +: CB];
    end
  end

  // Stage 1: edge and offset vectors.
  logic                 v1_q;
  logic signed [CB:0]   ab1_q [3], ac1_q [3], np1_q [3], rr1_q [3], pq1_q [3];
  logic signed [CB-1:0] p1_q [3];
  logic [IdW-1:0]       tid1_q, sid1_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ab1_q[i] <= (CB+1)'(b[i]) - (CB+1)'(a[i]);
      ac1_q[i] <= (CB+1)'(c[i]) - (CB+1)'(a[i]);
      np1_q[i] <= (CB+1)'(p[i]) - (CB+1)'(q[i]);
      rr1_q[i] <= (CB+1)'(p[i]) - (CB+1)'(a[i]);
      pq1_q[i] <= (CB+1)'(q[i]) - (CB+1)'(p[i]);
      p1_q[i]  <= p[i];
    end
    tid1_q <= req_i.tri_id;
    sid1_q <= req_i.seg_id;
  end

  // Stage 2: the partial products of the three cross products.
  logic                 v2_q;
  logic signed [PW-1:0] xa2_q [3][3], xb2_q [3][3];
  logic signed [CB:0]   ab2_q [3], rr2_q [3], pq2_q [3];
  logic signed [CB-1:0] p2_q [3];
  logic [IdW-1:0]       tid2_q, sid2_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      xa2_q[0][i] <= PW'(ac1_q[NXT[i]]) * PW'(np1_q[PRV[i]]);
      xb2_q[0][i] <= PW'(ac1_q[PRV[i]]) * PW'(np1_q[NXT[i]]);
      xa2_q[1][i] <= PW'(rr1_q[NXT[i]]) * PW'(np1_q[PRV[i]]);
      xb2_q[1][i] <= PW'(rr1_q[PRV[i]]) * PW'(np1_q[NXT[i]]);
      xa2_q[2][i] <= PW'(ac1_q[NXT[i]]) * PW'(rr1_q[PRV[i]]);
      xb2_q[2][i] <= PW'(ac1_q[PRV[i]]) * PW'(rr1_q[NXT[i]]);
      ab2_q[i] <= ab1_q[i];
      rr2_q[i] <= rr1_q[i];
      pq2_q[i] <= pq1_q[i];
      p2_q[i]  <= p1_q[i];
    end
    tid2_q <= tid1_q;
    sid2_q <= sid1_q;
  end

  // Stage 3: finish the cross products and form the dot-product terms.
  logic signed [KW-1:0] k [3][3];
  logic                 v3_q;
  logic signed [DW-1:0] dp3_q [4][3];
  logic signed [CB:0]   pq3_q [3];
  logic signed [CB-1:0] p3_q [3];
  logic [IdW-1:0]       tid3_q, sid3_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        k[j][i] = KW'(xa2_q[j][i]) - KW'(xb2_q[j][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dp3_q[0][i] <= DW'(ab2_q[i]) * DW'(k[0][i]);
      dp3_q[1][i] <= DW'(rr2_q[i]) * DW'(k[0][i]);
      dp3_q[2][i] <= DW'(ab2_q[i]) * DW'(k[1][i]);
      dp3_q[3][i] <= DW'(ab2_q[i]) * DW'(k[2][i]);
      pq3_q[i] <= pq2_q[i];
      p3_q[i]  <= p2_q[i];
    end
    tid3_q <= tid2_q;
    sid3_q <= sid2_q;
  end

  // Stage 4: sum the terms.
  always_ff @(posedge clk_i) begin
    det_o <= W'(dp3_q[0][0]) + W'(dp3_q[0][1]) + W'(dp3_q[0][2]);
    nu_o  <= W'(dp3_q[1][0]) + W'(dp3_q[1][1]) + W'(dp3_q[1][2]);
    nv_o  <= W'(dp3_q[2][0]) + W'(dp3_q[2][1]) + W'(dp3_q[2][2]);
    nt_o  <= W'(dp3_q[3][0]) + W'(dp3_q[3][1]) + W'(dp3_q[3][2]);
    for (int i = 0; i < 3; i++) begin
      pq_o[i] <= pq3_q[i];
      p_o[i]  <= p3_q[i];
    end
    tri_id_o <= tid3_q;
    seg_id_o <= sid3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      valid_o <= v3_q;
    end
  end

endmodule

[rtl/sti_div_step.sv]
// One registered restoring-division step, shared divisor, three coordinate lanes.
module sti_div_step #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32,
  parameter int unsigned QB = 16,
  parameter int unsigned K  = 0
) (
  input  logic          clk_i,
  input  logic [NW-1:0] rem_i [3],
  input  logic [QB-1:0] quo_i [3],
  input  logic [DW-1:0] div_i,
  output logic [NW-1:0] rem_o [3],
  output logic [QB-1:0] quo_o [3],
  output logic [DW-1:0] div_o
);

  logic [NW-1:0] shifted;

  assign shifted = NW'(div_i) << K;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (rem_i[i] >= shifted) begin
        rem_o[i] <= rem_i[i] - shifted;
        quo_o[i] <= quo_i[i] | (QB'(1) << K);
      end else begin
        rem_o[i] <= rem_i[i];
        quo_o[i] <= quo_i[i];
      end
    end
    div_o <= div_i;
  end

endmodule

[rtl/segment_triangle_intersect_core.sv]
// Top level of the pipelined segment/triangle intersection core.
// A request is taken on every clock cycle in which start_i is high; busy_o is
// always low, because the pipeline never stalls and the receiver has no way to
// hold results off. Each request yields exactly one result, shown for a single
// cycle with result_valid_o high. Its path runs through the four determinant
// stages, one stage for the sign and range tests, one for the contact-point
// products and one restoring-division stage per bit of the contact offset,
// followed by the output register. Throughput is one request per cycle
// throughout. The singular tolerance is written through its own channel,
// which is always ready; it is read directly by the range test, so it should
// only be changed while no request is in flight. A result with hit low
// carries a contact point of zero; identifiers are always passed through.
module segment_triangle_intersect_core #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  sti_pkg::sti_req_t        req_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [sti_pkg::TolW-1:0] cfg_data_i,
  output logic                     result_valid_o,
  output sti_pkg::sti_res_t        result_o
);
  import sti_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned W   = 3 * CB + 7;   // signed determinant width
  localparam int unsigned UW  = W - 1;        // magnitude after sign folding
  localparam int unsigned DVW = UW + 1;       // doubled determinant
  localparam int unsigned QB  = CB;           // contact offset never exceeds |PQ|
  localparam int unsigned NW  = UW + CB + 2;  // rounding numerator
  localparam int unsigned XW  = CB + 2;
  localparam int unsigned OW  = (3 * CB > FieldW) ? 3 * CB : FieldW;
  localparam int unsigned SBW = 1 + 3 + 3 * CB + 2 * IdW;
  localparam logic signed [XW-1:0] XMAX = XW'((1 << (CB - 1)) - 1);
  localparam logic signed [XW-1:0] XMIN = -XMAX - XW'(1);

  // The tolerance register; the channel never pushes back.
  logic [TolW-1:0] tol_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  // Determinant pipeline.
  logic                 g_valid;
  logic signed [W-1:0]  g_det, g_nu, g_nv, g_nt;
  logic signed [CB-1:0] g_p [3];
  logic signed [CB:0]   g_pq [3];
  logic [IdW-1:0]       g_tid, g_sid;

  sti_geom #(.CB(CB)) u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i && !busy_o),
    .req_i    (req_i),
    .valid_o  (g_valid),
    .det_o    (g_det),
    .nu_o     (g_nu),
    .nv_o     (g_nv),
    .nt_o     (g_nt),
    .p_o      (g_p),
    .pq_o     (g_pq),
    .tri_id_o (g_tid),
    .seg_id_o (g_sid)
  );

  // Sign folding and the hit test. All numerators are negated together with
  // the determinant so that the tests read against a positive denominator.
  logic                 neg;
  logic signed [W-1:0]  det_n, nu_n, nv_n, nt_n;
  logic signed [W+1:0]  uv_slack, t_slack;
  logic                 hit_d;

  always_comb begin
    neg      = g_det[W-1];
    det_n    = neg ? -g_det : g_det;
    nu_n     = neg ? -g_nu  : g_nu;
    nv_n     = neg ? -g_nv  : g_nv;
    nt_n     = neg ? -g_nt  : g_nt;
    uv_slack = (W+2)'(det_n) - (W+2)'(nu_n) - (W+2)'(nv_n);
    t_slack  = (W+2)'(det_n) - (W+2)'(nt_n);
    hit_d    = (det_n > W'(tol_q)) && !nu_n[W-1] && !nv_n[W-1] && !uv_slack[W+1]
               && !nt_n[W-1] && !t_slack[W+1];
  end

  logic                 v5_q, hit5_q;
  logic [UW-1:0]        det5_q, nt5_q;
  logic signed [CB-1:0] p5_q [3];
  logic signed [CB:0]   pq5_q [3];
  logic [IdW-1:0]       tid5_q, sid5_q;

  always_ff @(posedge clk_i) begin
    hit5_q <= hit_d;
    det5_q <= det_n[UW-1:0];
    nt5_q  <= nt_n[UW-1:0];
    for (int i = 0; i < 3; i++) begin
      p5_q[i]  <= g_p[i];
      pq5_q[i] <= g_pq[i];
    end
    tid5_q <= g_tid;
    sid5_q <= g_sid;
  end

  // Contact offset numerators: 2 * nt * |PQ| + det, over 2 * det, rounds
  // t * |PQ| to the nearest step with halves going away from P.
  logic [CB-1:0] pq_mag [3];
  logic [NW-1:0] prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pq_mag[i] = pq5_q[i][CB] ? CB'(-pq5_q[i]) : CB'(pq5_q[i]);
      prod[i]   = NW'(nt5_q) * NW'(pq_mag[i]);
    end
  end

  logic [NW-1:0]  rem_s [QB+1][3];
  logic [QB-1:0]  quo_s [QB+1][3];
  logic [DVW-1:0] div_s [QB+1];
  logic [SBW-1:0] sb_s  [QB+1];
  logic           v_s   [QB+1];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      rem_s[0][i] <= (prod[i] << 1) + NW'(det5_q);
      quo_s[0][i] <= '0;
    end
    div_s[0] <= {det5_q, 1'b0};
    sb_s[0]  <= {hit5_q, pq5_q[2][CB], pq5_q[1][CB], pq5_q[0][CB],
                 p5_q[2], p5_q[1], p5_q[0], tid5_q, sid5_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q   <= 1'b0;
      v_s[0] <= 1'b0;
    end else begin
      v5_q   <= g_valid;
      v_s[0] <= v5_q;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < QB; s++) begin : g_div
    sti_div_step #(
      .NW (NW),
      .DW (DVW),
      .QB (QB),
      .K  (QB - 1 - s)
    ) u_step (
      .clk_i (clk_i),
      .rem_i (rem_s[s]),
      .quo_i (quo_s[s]),
      .div_i (div_s[s]),
      .rem_o (rem_s[s+1]),
      .quo_o (quo_s[s+1]),
      .div_o (div_s[s+1])
    );

    always_ff @(posedge clk_i) begin
      sb_s[s+1] <= sb_s[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[s+1] <= 1'b0;
      end else begin
        v_s[s+1] <= v_s[s];
      end
    end
  end

  // Contact point: step from P along the sign of PQ, then saturate.
  logic [SBW-1:0]       sb_f;
  logic                 hit_f;
  logic [2:0]           neg_f;
  logic signed [CB-1:0] p_f [3];
  logic signed [XW-1:0] x_f [3];
  logic [OW-1:0]        packed_f;

  always_comb begin
    sb_f     = sb_s[QB];
    hit_f    = sb_f[SBW-1];
    neg_f    = sb_f[SBW-2 -: 3];
    packed_f = '0;
    for (int i = 0; i < 3; i++) begin
      p_f[i] = sb_f[2*IdW + i*CB +: CB];
      x_f[i] = neg_f[i] ? XW'(p_f[i]) - XW'(quo_s[QB][i])
                        : XW'(p_f[i]) + XW'(quo_s[QB][i]);
      if (x_f[i] > XMAX) begin
        x_f[i] = XMAX;
      end else if (x_f[i] < XMIN) begin
        x_f[i] = XMIN;
      end
      packed_f[i*CB +: CB] = x_f[i][CB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    result_o.hit           <= hit_f;
    result_o.contact_point <= hit_f ? packed_f[FieldW-1:0] : '0;
    result_o.tri_id_out    <= sb_f[IdW +: IdW];
    result_o.seg_id_out    <= sb_f[IdW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= v_s[QB];
    end
  end

endmodule

[tb/sv/segment_triangle_intersect_core_tb.sv]
// Self-checking testbench for the segment/triangle intersection core.
`timescale 1ns / 100ps

module segment_triangle_intersect_core_tb;
  import sti_pkg::*;

  localparam int unsigned CoordW      = 16;
  localparam int unsigned Latency     = CoordW + 7;
  localparam int unsigned SettleWait  = Latency + 10;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandomItems = 630;
  localparam int unsigned NumPhases   = 5;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start_i        = 1'b0;
  logic                busy_o;
  sti_req_t            req_i          = '0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [TolW-1:0]     cfg_data_i     = '0;
  logic                result_valid_o;
  sti_res_t            result_o;

  // Requests waiting to be offered, results awaited from the core.
  sti_req_t        pending_reqs[$];
  sti_res_t        awaited_results[$];
  // Our own copy of the singular tolerance, updated on each register write.
  logic [TolW-1:0] tolerance_copy = '0;
  int unsigned     sender_idle_pct = 0;
  int unsigned     fail_count      = 0;
  int unsigned     reqs_taken      = 0;
  int unsigned     results_seen    = 0;
  int unsigned     hits_seen       = 0;
  int unsigned     quiet_cycles    = 0;

  segment_triangle_intersect_core #(
    .COORD_BITS(CoordW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_i         (req_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Extracts one signed coordinate (0 = x, 1 = y, 2 = z) from a packed point.
  function automatic longint coord_of(logic [FieldW-1:0] pt, int axis);
    return longint'($signed(pt[axis*CoordW +: CoordW]));
  endfunction

  // Packs three coordinates into the point format; values are already in range.
  function automatic logic [FieldW-1:0] pack_point(longint x, longint y, longint z);
    logic [CoordW-1:0] cx, cy, cz;
    cx = x[CoordW-1:0];
    cy = y[CoordW-1:0];
    cz = z[CoordW-1:0];
    return {cz, cy, cx};
  endfunction

  // Works out the expected result of one request. The linear system
  // u*AB + v*AC - t*PQ = P - A is solved exactly with Cramer's rule; every
  // quantity up to the numerators fits comfortably in 64 bits, and the
  // contact offset is formed in 128 bits before the rounding division.
  function automatic sti_res_t predict_crossing(sti_req_t r, logic [TolW-1:0] tol);
    sti_res_t    res;
    longint      a[3], b[3], c[3], p[3], q[3];
    longint      ab[3], ac[3], np[3], rp[3], pq[3], k[3];
    longint      det, nu, nv, nt, x, lim_hi, lim_lo;
    logic [127:0] num, den, quo;
    longint      mag, delta;
    logic [FieldW-1:0] packed_pt;
    for (int i = 0; i < 3; i++) begin
      a[i] = coord_of(r.vertex_a, i);
      b[i] = coord_of(r.vertex_b, i);
      c[i] = coord_of(r.vertex_c, i);
      p[i] = coord_of(r.seg_start, i);
      q[i] = coord_of(r.seg_end, i);
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      pq[i] = q[i] - p[i];
      np[i] = -pq[i];
      rp[i] = p[i] - a[i];
    end
    k[0] = ac[1]*np[2] - ac[2]*np[1];
    k[1] = ac[2]*np[0] - ac[0]*np[2];
    k[2] = ac[0]*np[1] - ac[1]*np[0];
    det = ab[0]*k[0] + ab[1]*k[1] + ab[2]*k[2];
    nu  = rp[0]*k[0] + rp[1]*k[1] + rp[2]*k[2];
    k[0] = rp[1]*np[2] - rp[2]*np[1];
    k[1] = rp[2]*np[0] - rp[0]*np[2];
    k[2] = rp[0]*np[1] - rp[1]*np[0];
    nv = ab[0]*k[0] + ab[1]*k[1] + ab[2]*k[2];
    k[0] = ac[1]*rp[2] - ac[2]*rp[1];
    k[1] = ac[2]*rp[0] - ac[0]*rp[2];
    k[2] = ac[0]*rp[1] - ac[1]*rp[0];
    nt = ab[0]*k[0] + ab[1]*k[1] + ab[2]*k[2];
    // Normalise to a positive determinant so the range tests are one-sided.
    if (det < 0) begin
      det = -det;
      nu  = -nu;
      nv  = -nv;
      nt  = -nt;
    end
    lim_hi = (longint'(1) <<< (CoordW - 1)) - 1;
    lim_lo = -lim_hi - 1;
    packed_pt = '0;
    res.hit = 1'b0;
    if (det > longint'(tol) && nu >= 0 && nv >= 0 && det - (nu + nv) >= 0 &&
        nt >= 0 && det - nt >= 0) begin
      res.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
        mag = (pq[i] < 0) ? -pq[i] : pq[i];
        // Rounds the offset t*|PQ| to nearest, with halves going away from P.
        num = 128'(nt) * 128'(mag) * 2 + 128'(det);
        den = 128'(det) * 2;
        quo = num / den;
        delta = longint'(quo[63:0]);
        x = (pq[i] < 0) ? p[i] - delta : p[i] + delta;
        if (x > lim_hi) x = lim_hi;
        if (x < lim_lo) x = lim_lo;
        packed_pt[i*CoordW +: CoordW] = x[CoordW-1:0];
      end
    end
    res.contact_point = packed_pt;
    res.tri_id_out    = r.tri_id;
    res.seg_id_out    = r.seg_id;
    return res;
  endfunction

  // Request driver. A request is taken when start_i is high and busy_o low;
  // the prediction is made at that edge with the tolerance then in force.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && busy_o)) begin
      if (start_i) begin
        awaited_results.push_back(predict_crossing(req_i, tolerance_copy));
        reqs_taken++;
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        start_i <= 1'b1;
        req_i   <= pending_reqs.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Tolerance copy follows completed register writes.
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) tolerance_copy <= cfg_data_i;
  end

  // Result monitor: every strobed result is matched against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    sti_res_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result %h with nothing outstanding", $time, result_o);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (result_o.hit) hits_seen++;
        if (result_o.hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %b actual %b", $time, want.hit,
                   result_o.hit);
          fail_count++;
        end
        if (result_o.contact_point !== want.contact_point) begin
          $display("%0t: contact point mismatch, expected %h actual %h", $time,
                   want.contact_point, result_o.contact_point);
          fail_count++;
        end
        if (result_o.tri_id_out !== want.tri_id_out) begin
          $display("%0t: triangle id mismatch, expected %h actual %h", $time,
                   want.tri_id_out, result_o.tri_id_out);
          fail_count++;
        end
        if (result_o.seg_id_out !== want.seg_id_out) begin
          $display("%0t: segment id mismatch, expected %h actual %h", $time,
                   want.seg_id_out, result_o.seg_id_out);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: the run is abandoned if nothing is accepted for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic sti_req_t make_req(logic [FieldW-1:0] pa, logic [FieldW-1:0] pb,
                                        logic [FieldW-1:0] pc, logic [FieldW-1:0] ps,
                                        logic [FieldW-1:0] pe);
    sti_req_t r;
    r.vertex_a  = pa;
    r.vertex_b  = pb;
    r.vertex_c  = pc;
    r.seg_start = ps;
    r.seg_end   = pe;
    r.tri_id    = IdW'($urandom);
    r.seg_id    = IdW'($urandom);
    return r;
  endfunction

  // Builds a segment that genuinely passes through (or ends on) a random
  // triangle, so that most random requests reach the contact-point path.
  function automatic sti_req_t crossing_req();
    longint a[3], b[3], c[3], xp[3], d[3], pp[3], qq[3];
    longint u, v, kq;
    u = $urandom_range(256);
    v = $urandom_range(256 - u);
    kq = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($urandom_range(4000)) - 2000;
      b[i] = longint'($urandom_range(4000)) - 2000;
      c[i] = longint'($urandom_range(4000)) - 2000;
      xp[i] = a[i] + ((b[i] - a[i]) * u + (c[i] - a[i]) * v) / 256;
      d[i] = longint'($urandom_range(12000)) - 6000;
      pp[i] = xp[i] - d[i];
      qq[i] = xp[i] + d[i] * kq;
    end
    return make_req(pack_point(a[0], a[1], a[2]), pack_point(b[0], b[1], b[2]),
                    pack_point(c[0], c[1], c[2]), pack_point(pp[0], pp[1], pp[2]),
                    pack_point(qq[0], qq[1], qq[2]));
  endfunction

  function automatic logic [FieldW-1:0] small_point();
    return pack_point(longint'($urandom_range(600)) - 300,
                      longint'($urandom_range(600)) - 300,
                      longint'($urandom_range(600)) - 300);
  endfunction

  // A point with every bit random.
  function automatic logic [FieldW-1:0] random_word();
    return FieldW'({$urandom, $urandom});
  endfunction

  // Writes the tolerance register through its handshake.
  task automatic write_tolerance(logic [TolW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Lets every outstanding request complete before the core is touched again.
  task automatic drain_core();
    while (pending_reqs.size() > 0 || start_i || awaited_results.size() > 0)
      @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  initial begin
    logic [TolW-1:0] tol_plan[NumPhases];
    int unsigned     idle_plan[NumPhases];
    int unsigned     pick;
    logic [FieldW-1:0] ta, tb, tc;

    tol_plan  = '{16'h0000, 16'hFFFF, 16'd1000, 16'h0000, 16'h0001};
    idle_plan = '{24, 24, 54, 54, 0};
    tol_plan[3] = TolW'($urandom);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests against a right triangle in the z = 0 plane:
    // A = origin, B = 256 along x, C = 256 along y.
    ta = pack_point(0, 0, 0);
    tb = pack_point(256, 0, 0);
    tc = pack_point(0, 256, 0);
    write_tolerance(16'h0000);
    sender_idle_pct = idle_plan[0];
    // A plain crossing through the interior.
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(64, 64, -256),
                                    pack_point(64, 64, 256)));
    // Crossings on the edges u = 0, v = 0 and u + v = 1.
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(0, 100, -50),
                                    pack_point(0, 100, 50)));
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(100, 0, -50),
                                    pack_point(100, 0, 50)));
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(128, 128, -50),
                                    pack_point(128, 128, 50)));
    // Segment starting on the plane (t = 0) and ending on it (t = 1).
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(30, 40, 0),
                                    pack_point(90, 10, 300)));
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(90, 10, -300),
                                    pack_point(30, 40, 0)));
    // Just outside: past the hypotenuse, and a segment stopping short.
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(129, 128, -50),
                                    pack_point(129, 128, 50)));
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(64, 64, 10),
                                    pack_point(64, 64, 300)));
    // Contact coordinates exactly halfway between steps, in both directions.
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(10, 10, -1),
                                    pack_point(13, 7, 1)));
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(10, 10, -1),
                                    pack_point(7, 13, 1)));
    // Segment parallel to the triangle, a collapsed triangle, all zero.
    pending_reqs.push_back(make_req(ta, tb, tc, pack_point(20, 20, 5),
                                    pack_point(80, 30, 5)));
    pending_reqs.push_back(make_req(ta, ta, tc, pack_point(20, 20, -5),
                                    pack_point(20, 20, 5)));
    pending_reqs.push_back(make_req('0, '0, '0, '0, '0));
    // Extremes of the coordinate range and all-ones fields.
    pending_reqs.push_back(make_req(pack_point(-32768, -32768, 0),
                                    pack_point(32767, -32768, 0),
                                    pack_point(-32768, 32767, 0),
                                    pack_point(0, 0, -32768),
                                    pack_point(0, 0, 32767)));
    pending_reqs.push_back(make_req(pack_point(-32768, -32768, -32768),
                                    pack_point(32767, 32767, -32768),
                                    pack_point(32767, -32768, 32767),
                                    pack_point(-32768, 32767, 32767),
                                    pack_point(32767, -32768, -32768)));
    pending_reqs.push_back(make_req('1, '0, '1, '1, '0));
    begin
      sti_req_t r;
      r = make_req('1, '1, '1, '1, '1);
      r.tri_id = '1;
      r.seg_id = '1;
      pending_reqs.push_back(r);
      r = make_req(ta, tb, tc, pack_point(64, 64, -256), pack_point(64, 64, 256));
      r.tri_id = '0;
      r.seg_id = '0;
      pending_reqs.push_back(r);
    end

    // Random phases, each with the tolerance and idling pattern of its plan
    // entry. The core is drained before every register write, which also makes
    // the sender wait until every expected result has arrived.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_core();
      write_tolerance(tol_plan[ph]);
      sender_idle_pct = idle_plan[ph];
      for (int n = 0; n < RandomItems / NumPhases; n++) begin
        pick = $urandom_range(99);
        if (pick < 65)
          pending_reqs.push_back(crossing_req());
        else if (pick < 80)
          pending_reqs.push_back(make_req(small_point(), small_point(), small_point(),
                                          small_point(), small_point()));
        else
          pending_reqs.push_back(make_req(random_word(), random_word(), random_word(),
                                          random_word(), random_word()));
      end
    end

    drain_core();
    $display("Covered %0d requests and %0d results (%0d hits) over %0d tolerance settings.",
             reqs_taken, results_seen, hits_seen, NumPhases + 1);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
